/* rtl/fmf_pkg.sv */
// Shared types and constants for the message fragmenter.
package fmf_pkg;

   localparam int CHUNK_MAX = 56;
   localparam int CHUNK_MIN = 3;
   localparam int BUF_AW = $clog2(CHUNK_MAX);
   localparam int FILL_W = $clog2(CHUNK_MAX + 1);
   localparam int CHUNK_W = 6;
   localparam int MSG_ID_BYTES = 2;
   localparam int HDR_W = 3;
   localparam logic [HDR_W-1:0] HDR_SHORT_LAST = 3'd3;
   localparam logic [HDR_W-1:0] HDR_LONG_LAST = 3'd7;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_MASK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_MASK = 2'd2;

   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_DATA  = 2'd1,
      OP_END   = 2'd2,
      OP_ABORT = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BUSY       = 3'd1,
      ST_NOT_ACTIVE = 3'd2,
      ST_TOO_LONG   = 3'd3,
      ST_MISMATCH   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_ID_LO,
      S_HDR,
      S_PAY
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  channel;
      logic [15:0] msg_id;
      logic [31:0] body_bytes;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       byte_valid;
      status_type status;
      logic       run_end;
   } rsp_item_type;

   typedef struct packed {
      logic [CHUNK_W-1:0] chunk_size;
      logic [7:0]         first_mask;
      logic [7:0]         last_mask;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [BUF_AW-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [BUF_AW-1:0] raddr;
   } ram_cmd_type;

endpackage

/* rtl/fmf_ifs.sv */
// Valid/ready channel interfaces for request and response items.
interface fmf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [7:0]  channel;
   logic [15:0] msg_id;
   logic [31:0] body_bytes;
   logic [7:0]  data_byte;

   modport source (output valid, output op, output channel, output msg_id,
                   output body_bytes, output data_byte, input ready);
   modport sink (input valid, input op, input channel, input msg_id,
                 input body_bytes, input data_byte, output ready);
endinterface

interface fmf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       byte_valid;
   logic [2:0] status;
   logic       run_end;

   modport source (output valid, output frame_byte, output byte_valid,
                   output status, output run_end, input ready);
   modport sink (input valid, input frame_byte, input byte_valid,
                 input status, input run_end, output ready);
endinterface

/* rtl/fmf_buf_ram.sv */
// Chunk buffer: one write port, one registered read port.
module fmf_buf_ram (
   input  logic                clock,
   input  fmf_pkg::ram_cmd_type cmd,
   output logic [7:0]          rdata
);

   logic [7:0] mem [fmf_pkg::CHUNK_MAX];

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.re) begin
         rdata <= mem[cmd.raddr];
      end
   end

endmodule

/* rtl/fmf_ctrl.sv */
// Message state, item decode and frame sequencer around the chunk buffer.
module fmf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fmf_pkg::req_item_type req_item,
   input  fmf_pkg::cfg_type      cfg,
   input  logic                  slot_free,
   output logic                  push,
   output fmf_pkg::rsp_item_type rsp_item,
   output fmf_pkg::ram_cmd_type  ram_cmd,
   input  logic [7:0]            ram_rdata
);

   fmf_pkg::state_type state_ff, state_in;
   fmf_pkg::req_item_type item_ff, item_in;

   logic                       active_ff, active_in;
   logic [7:0]                 chan_ff, chan_in;
   logic [31:0]                total_ff, total_in;
   logic [31:0]                sent_ff, sent_in;
   logic [fmf_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic                       first_ff, first_in;

   logic [7:0]                 frm_ch_ff, frm_ch_in;
   logic [7:0]                 frm_flags_ff, frm_flags_in;
   logic [fmf_pkg::FILL_W-1:0] frm_n_ff, frm_n_in;
   logic                       frm_long_ff, frm_long_in;
   logic [31:0]                frm_total_ff, frm_total_in;
   logic [fmf_pkg::HDR_W-1:0]  hdr_idx_ff, hdr_idx_in;
   logic [fmf_pkg::BUF_AW-1:0] pay_idx_ff, pay_idx_in;

   logic [fmf_pkg::CHUNK_W-1:0] eff_chunk;
   logic [32:0]                 have;
   logic [32:0]                 total33;
   logic                        too_long;
   logic [fmf_pkg::FILL_W-1:0]  fill_inc;
   logic                        emit_mid;
   logic                        len_ok;
   logic [7:0]                  flags_first;
   logic                        hdr_is_last;
   logic                        pay_is_last;
   logic [7:0]                  hdr_byte;

   // Decode against current message state.
   always_comb begin
      if (cfg.chunk_size < fmf_pkg::CHUNK_W'(fmf_pkg::CHUNK_MIN)) begin
         eff_chunk = fmf_pkg::CHUNK_W'(fmf_pkg::CHUNK_MIN);
      end else if (cfg.chunk_size > fmf_pkg::CHUNK_W'(fmf_pkg::CHUNK_MAX)) begin
         eff_chunk = fmf_pkg::CHUNK_W'(fmf_pkg::CHUNK_MAX);
      end else begin
         eff_chunk = cfg.chunk_size;
      end
      have = 33'(sent_ff) + 33'(fill_ff);
      total33 = 33'(total_ff);
      too_long = (have >= total33) || (fill_ff >= fmf_pkg::FILL_W'(fmf_pkg::CHUNK_MAX));
      fill_inc = fill_ff + fmf_pkg::FILL_W'(1);
      emit_mid = (7'(fill_inc) >= 7'(eff_chunk)) && ((have + 33'd1) < total33);
      len_ok = (have == total33);
      flags_first = first_ff ? 8'h00 : cfg.first_mask;
      hdr_is_last = (hdr_idx_ff == (frm_long_ff ? fmf_pkg::HDR_LONG_LAST
                                                : fmf_pkg::HDR_SHORT_LAST));
      pay_is_last = (fmf_pkg::FILL_W'(pay_idx_ff) == frm_n_ff - fmf_pkg::FILL_W'(1));
      case (hdr_idx_ff)
         3'd0:    hdr_byte = frm_ch_ff;
         3'd1:    hdr_byte = frm_flags_ff;
         3'd2:    hdr_byte = 8'h00;
         3'd3:    hdr_byte = 8'(frm_n_ff);
         3'd4:    hdr_byte = frm_total_ff[31:24];
         3'd5:    hdr_byte = frm_total_ff[23:16];
         3'd6:    hdr_byte = frm_total_ff[15:8];
         default: hdr_byte = frm_total_ff[7:0];
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fmf_pkg::S_IDLE: begin
            if (req_valid) state_in = fmf_pkg::S_EXEC;
         end
         fmf_pkg::S_EXEC: begin
            if (slot_free) begin
               state_in = fmf_pkg::S_IDLE;
               case (item_ff.op)
                  fmf_pkg::OP_BEGIN: begin
                     if (!active_ff) state_in = fmf_pkg::S_ID_LO;
                  end
                  fmf_pkg::OP_DATA: begin
                     if (active_ff && !too_long && emit_mid) state_in = fmf_pkg::S_HDR;
                  end
                  fmf_pkg::OP_END: begin
                     if (active_ff && len_ok) state_in = fmf_pkg::S_HDR;
                  end
                  default: state_in = fmf_pkg::S_IDLE;
               endcase
            end
         end
         fmf_pkg::S_ID_LO: state_in = fmf_pkg::S_IDLE;
         fmf_pkg::S_HDR: begin
            if (slot_free && hdr_is_last) begin
               state_in = (frm_n_ff == '0) ? fmf_pkg::S_IDLE : fmf_pkg::S_PAY;
            end
         end
         fmf_pkg::S_PAY: begin
            if (slot_free && pay_is_last) state_in = fmf_pkg::S_IDLE;
         end
         default: state_in = fmf_pkg::S_IDLE;
      endcase
   end

   // Handshake, result and buffer port.
   always_comb begin
      req_ready = (state_ff == fmf_pkg::S_IDLE);
      push = 1'b0;
      rsp_item = '0;
      rsp_item.run_end = 1'b1;
      rsp_item.status = fmf_pkg::ST_OK;
      ram_cmd = '0;
      case (state_ff)
         fmf_pkg::S_EXEC: begin
            if (slot_free) begin
               case (item_ff.op)
                  fmf_pkg::OP_BEGIN: begin
                     push = 1'b1;
                     if (active_ff) begin
                        rsp_item.status = fmf_pkg::ST_BUSY;
                     end else begin
                        ram_cmd.we = 1'b1;
                        ram_cmd.waddr = '0;
                        ram_cmd.wdata = item_ff.msg_id[15:8];
                     end
                  end
                  fmf_pkg::OP_DATA: begin
                     if (!active_ff) begin
                        push = 1'b1;
                        rsp_item.status = fmf_pkg::ST_NOT_ACTIVE;
                     end else if (too_long) begin
                        push = 1'b1;
                        rsp_item.status = fmf_pkg::ST_TOO_LONG;
                     end else begin
                        ram_cmd.we = 1'b1;
                        ram_cmd.waddr = fill_ff[fmf_pkg::BUF_AW-1:0];
                        ram_cmd.wdata = item_ff.data_byte;
                        push = !emit_mid;
                     end
                  end
                  fmf_pkg::OP_END: begin
                     if (!active_ff) begin
                        push = 1'b1;
                        rsp_item.status = fmf_pkg::ST_NOT_ACTIVE;
                     end else if (!len_ok) begin
                        push = 1'b1;
                        rsp_item.status = fmf_pkg::ST_MISMATCH;
                     end
                  end
                  default: push = 1'b1;
               endcase
            end
         end
         fmf_pkg::S_ID_LO: begin
            ram_cmd.we = 1'b1;
            ram_cmd.waddr = fmf_pkg::BUF_AW'(1);
            ram_cmd.wdata = item_ff.msg_id[7:0];
         end
         fmf_pkg::S_HDR: begin
            if (slot_free) begin
               push = 1'b1;
               rsp_item.frame_byte = hdr_byte;
               rsp_item.byte_valid = 1'b1;
               rsp_item.run_end = hdr_is_last && (frm_n_ff == '0);
               // prefetch first payload byte under the last header byte
               if (hdr_is_last && (frm_n_ff != '0)) begin
                  ram_cmd.re = 1'b1;
                  ram_cmd.raddr = '0;
               end
            end
         end
         fmf_pkg::S_PAY: begin
            if (slot_free) begin
               push = 1'b1;
               rsp_item.frame_byte = ram_rdata;
               rsp_item.byte_valid = 1'b1;
               rsp_item.run_end = pay_is_last;
               if (!pay_is_last) begin
                  ram_cmd.re = 1'b1;
                  ram_cmd.raddr = pay_idx_ff + fmf_pkg::BUF_AW'(1);
               end
            end
         end
         default: push = 1'b0;
      endcase
   end

   // Message state and frame capture.
   always_comb begin
      logic do_clear;
      logic do_frame;
      logic last_frame;
      do_clear = 1'b0;
      do_frame = 1'b0;
      last_frame = 1'b0;
      item_in = item_ff;
      active_in = active_ff;
      chan_in = chan_ff;
      total_in = total_ff;
      sent_in = sent_ff;
      fill_in = fill_ff;
      first_in = first_ff;
      frm_ch_in = frm_ch_ff;
      frm_flags_in = frm_flags_ff;
      frm_n_in = frm_n_ff;
      frm_long_in = frm_long_ff;
      frm_total_in = frm_total_ff;
      hdr_idx_in = hdr_idx_ff;
      pay_idx_in = pay_idx_ff;
      case (state_ff)
         fmf_pkg::S_IDLE: begin
            if (req_valid) item_in = req_item;
         end
         fmf_pkg::S_EXEC: begin
            if (slot_free) begin
               case (item_ff.op)
                  fmf_pkg::OP_BEGIN: begin
                     if (!active_ff) begin
                        active_in = 1'b1;
                        chan_in = item_ff.channel;
                        total_in = item_ff.body_bytes + 32'(fmf_pkg::MSG_ID_BYTES);
                        sent_in = '0;
                        first_in = 1'b0;
                        fill_in = fmf_pkg::FILL_W'(fmf_pkg::MSG_ID_BYTES);
                     end
                  end
                  fmf_pkg::OP_DATA: begin
                     if (active_ff && !too_long) begin
                        fill_in = fill_inc;
                        if (emit_mid) begin
                           do_frame = 1'b1;
                           frm_n_in = fill_inc;
                           sent_in = sent_ff + 32'(fill_inc);
                           fill_in = '0;
                        end
                     end
                  end
                  fmf_pkg::OP_END: begin
                     if (active_ff) begin
                        do_clear = 1'b1;
                        if (len_ok) begin
                           do_frame = 1'b1;
                           last_frame = 1'b1;
                           frm_n_in = fill_ff;
                        end
                     end
                  end
                  default: do_clear = 1'b1;
               endcase
            end
         end
         fmf_pkg::S_HDR: begin
            if (slot_free) begin
               hdr_idx_in = hdr_is_last ? '0 : hdr_idx_ff + fmf_pkg::HDR_W'(1);
               pay_idx_in = '0;
            end
         end
         fmf_pkg::S_PAY: begin
            if (slot_free) pay_idx_in = pay_idx_ff + fmf_pkg::BUF_AW'(1);
         end
         default: hdr_idx_in = hdr_idx_ff;
      endcase
      if (do_frame) begin
         frm_ch_in = chan_ff;
         frm_flags_in = flags_first | (last_frame ? cfg.last_mask : 8'h00);
         frm_long_in = !first_ff && !last_frame;
         frm_total_in = total_ff;
         first_in = 1'b1;
         hdr_idx_in = '0;
      end
      if (do_clear) begin
         active_in = 1'b0;
         chan_in = '0;
         total_in = '0;
         sent_in = '0;
         fill_in = '0;
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fmf_pkg::S_IDLE;
         active_ff <= 1'b0;
         chan_ff <= '0;
         total_ff <= '0;
         sent_ff <= '0;
         fill_ff <= '0;
         first_ff <= 1'b0;
         hdr_idx_ff <= '0;
         pay_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         chan_ff <= chan_in;
         total_ff <= total_in;
         sent_ff <= sent_in;
         fill_ff <= fill_in;
         first_ff <= first_in;
         hdr_idx_ff <= hdr_idx_in;
         pay_idx_ff <= pay_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      frm_ch_ff <= frm_ch_in;
      frm_flags_ff <= frm_flags_in;
      frm_n_ff <= frm_n_in;
      frm_long_ff <= frm_long_in;
      frm_total_ff <= frm_total_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= fmf_pkg::FILL_W'(fmf_pkg::CHUNK_MAX))
      else $error("fill count beyond buffer depth");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> fill_ff == '0)
      else $error("buffered bytes with no open message");

   a_pay_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == fmf_pkg::S_PAY |-> frm_n_ff != '0)
      else $error("payload phase on an empty frame");

   a_byte_src: assert property (@(posedge clock) disable iff (reset)
      push && rsp_item.byte_valid |->
         (state_ff == fmf_pkg::S_HDR || state_ff == fmf_pkg::S_PAY))
      else $error("frame byte pushed outside frame emission");

   a_pay_read: assert property (@(posedge clock) disable iff (reset)
      ram_cmd.re |=> (state_ff == fmf_pkg::S_PAY))
      else $error("buffer read not followed by payload phase");

endmodule

/* rtl/message_fragmenter_first_last.sv */
// Top level: configuration registers, response register, control and buffer.
//
//  port    | role   | moves
//  req_ch  | sink   | op/channel/msg_id/body_bytes/data_byte item
//  rsp_ch  | source | frame_byte/byte_valid/status/run_end item
//  csr_*   | write  | chunk_size, first_flag_mask, last_flag_mask
//
// One item is in work at a time: it is accepted in S_IDLE and decoded in
// S_EXEC; begin adds an S_ID_LO state for the second message id byte write.
// A frame sends a 4 or 8 byte header, then one payload byte per cycle, set by
// the single read port of the chunk buffer; response stalls hold everything.
// The response register lets a new item be accepted while a result waits.
// Reset is synchronous; the chunk buffer is not cleared and needs no pass.
module message_fragmenter_first_last (
   input  logic                              clock,
   input  logic                              reset,
   fmf_req_if.sink                           req_ch,
   fmf_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [fmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fmf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   fmf_pkg::cfg_type      cfg_ff, cfg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fmf_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   fmf_pkg::req_item_type req_item;
   fmf_pkg::rsp_item_type ctrl_item;
   fmf_pkg::ram_cmd_type  ram_cmd;
   logic [7:0]            ram_rdata;
   logic                  slot_free;
   logic                  push;
   logic                  ctrl_ready;

   always_comb begin
      req_item.op = fmf_pkg::op_type'(req_ch.op);
      req_item.channel = req_ch.channel;
      req_item.msg_id = req_ch.msg_id;
      req_item.body_bytes = req_ch.body_bytes;
      req_item.data_byte = req_ch.data_byte;
   end

   assign req_ch.ready = ctrl_ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            fmf_pkg::CSR_CHUNK_SIZE: cfg_in.chunk_size = csr_wdata[fmf_pkg::CHUNK_W-1:0];
            fmf_pkg::CSR_FIRST_MASK: cfg_in.first_mask = csr_wdata;
            fmf_pkg::CSR_LAST_MASK:  cfg_in.last_mask = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in = rsp_item_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_item_in = ctrl_item;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chunk_size <= fmf_pkg::CHUNK_W'(fmf_pkg::CHUNK_MAX);
         cfg_ff.first_mask <= 8'h01;
         cfg_ff.last_mask <= 8'h02;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.frame_byte = rsp_item_ff.frame_byte;
   assign rsp_ch.byte_valid = rsp_item_ff.byte_valid;
   assign rsp_ch.status = rsp_item_ff.status;
   assign rsp_ch.run_end = rsp_item_ff.run_end;

   fmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctrl_ready),
      .req_item  (req_item),
      .cfg       (cfg_ff),
      .slot_free (slot_free),
      .push      (push),
      .rsp_item  (ctrl_item),
      .ram_cmd   (ram_cmd),
      .ram_rdata (ram_rdata)
   );

   fmf_buf_ram u_buf (
      .clock (clock),
      .cmd   (ram_cmd),
      .rdata (ram_rdata)
   );

endmodule

/* dv/tb_message_fragmenter_first_last.sv */
// Self-checking testbench for the message fragmenter: random paced traffic against a predictor.
`timescale 1ns / 1ps

module tb_message_fragmenter_first_last;

   localparam logic [fmf_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int ITEM_TARGET = 165;

   // Tracks the open message and the frame bytes it should produce.
   class fragmenter_mirror;
      logic [5:0]   chunk_reg;
      logic [7:0]   first_mask;
      logic [7:0]   last_mask;
      bit           active;
      logic [7:0]   msg_chan;
      logic [31:0]  total_len;
      logic [31:0]  sent_len;
      int           fill;
      bit           first_done;
      logic [7:0]   chunk_mem [fmf_pkg::CHUNK_MAX];
      fmf_pkg::rsp_item_type due[$];
      int           errors;

      function new();
         chunk_reg = 6'(fmf_pkg::CHUNK_MAX);
         first_mask = 8'h01;
         last_mask = 8'h02;
         errors = 0;
         clear_msg();
      endfunction

      function void clear_msg();
         active = 1'b0;
         msg_chan = '0;
         total_len = '0;
         sent_len = '0;
         fill = 0;
         first_done = 1'b0;
      endfunction

      function void write_reg(logic [fmf_pkg::CSR_IDX_W-1:0] idx,
                              logic [fmf_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            fmf_pkg::CSR_CHUNK_SIZE: chunk_reg = val[5:0];
            fmf_pkg::CSR_FIRST_MASK: first_mask = val;
            fmf_pkg::CSR_LAST_MASK: last_mask = val;
            default: ;
         endcase
      endfunction

      function int eff_chunk();
         if (chunk_reg < fmf_pkg::CHUNK_MIN) return fmf_pkg::CHUNK_MIN;
         if (chunk_reg > fmf_pkg::CHUNK_MAX) return fmf_pkg::CHUNK_MAX;
         return int'(chunk_reg);
      endfunction

      function void push_result(logic [7:0] b, logic v, fmf_pkg::status_type st, logic last);
         fmf_pkg::rsp_item_type r;
         r.frame_byte = b;
         r.byte_valid = v;
         r.status = st;
         r.run_end = last;
         due.push_back(r);
      endfunction

      function void emit_frame(bit last);
         logic [7:0] hdr [8];
         logic [7:0] flags;
         int n;
         int hlen;
         int total_n;
         n = (fill > fmf_pkg::CHUNK_MAX) ? fmf_pkg::CHUNK_MAX : fill;
         flags = '0;
         if (!first_done) flags = flags | first_mask;
         if (last) flags = flags | last_mask;
         hdr[0] = msg_chan;
         hdr[1] = flags;
         hdr[2] = 8'(n >> 8);
         hdr[3] = 8'(n);
         hlen = 4;
         // long header carries the message total on a first frame that is not the last
         if (!first_done && !last) begin
            hdr[4] = total_len[31:24];
            hdr[5] = total_len[23:16];
            hdr[6] = total_len[15:8];
            hdr[7] = total_len[7:0];
            hlen = 8;
         end
         total_n = hlen + n;
         for (int k = 0; k < hlen; k++)
            push_result(hdr[k], 1'b1, fmf_pkg::ST_OK, k == total_n - 1);
         for (int i = 0; i < n; i++)
            push_result(chunk_mem[i], 1'b1, fmf_pkg::ST_OK, hlen + i == total_n - 1);
         sent_len = sent_len + 32'(fill);
         fill = 0;
         first_done = 1'b1;
      endfunction

      function void note_request(fmf_pkg::req_item_type it);
         logic [32:0] have;
         have = {1'b0, sent_len} + 33'(fill);
         case (it.op)
            fmf_pkg::OP_BEGIN: begin
               if (active) begin
                  push_result('0, 1'b0, fmf_pkg::ST_BUSY, 1'b1);
               end else begin
                  active = 1'b1;
                  msg_chan = it.channel;
                  total_len = 32'd2 + it.body_bytes;
                  sent_len = '0;
                  first_done = 1'b0;
                  chunk_mem[0] = it.msg_id[15:8];
                  chunk_mem[1] = it.msg_id[7:0];
                  fill = 2;
                  push_result('0, 1'b0, fmf_pkg::ST_OK, 1'b1);
               end
            end
            fmf_pkg::OP_DATA: begin
               if (!active) begin
                  push_result('0, 1'b0, fmf_pkg::ST_NOT_ACTIVE, 1'b1);
               end else if (have + 33'd1 > {1'b0, total_len} || fill >= fmf_pkg::CHUNK_MAX) begin
                  push_result('0, 1'b0, fmf_pkg::ST_TOO_LONG, 1'b1);
               end else begin
                  chunk_mem[fill] = it.data_byte;
                  fill++;
                  have = have + 33'd1;
                  if (fill >= eff_chunk() && have < {1'b0, total_len})
                     emit_frame(1'b0);
                  else
                     push_result('0, 1'b0, fmf_pkg::ST_OK, 1'b1);
               end
            end
            fmf_pkg::OP_END: begin
               if (!active) begin
                  push_result('0, 1'b0, fmf_pkg::ST_NOT_ACTIVE, 1'b1);
               end else if (have != {1'b0, total_len}) begin
                  clear_msg();
                  push_result('0, 1'b0, fmf_pkg::ST_MISMATCH, 1'b1);
               end else begin
                  emit_frame(1'b1);
                  clear_msg();
               end
            end
            default: begin
               clear_msg();
               push_result('0, 1'b0, fmf_pkg::ST_OK, 1'b1);
            end
         endcase
      endfunction

      function void check_response(fmf_pkg::rsp_item_type got);
         fmf_pkg::rsp_item_type exp;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result byte=%0h valid=%0d status=%0d end=%0d", $time,
                     got.frame_byte, got.byte_valid, got.status, got.run_end);
            return;
         end
         exp = due.pop_front();
         if (got.frame_byte !== exp.frame_byte) begin
            errors++;
            $display("%0t: frame_byte expected %0h actual %0h", $time, exp.frame_byte,
                     got.frame_byte);
         end
         if (got.byte_valid !== exp.byte_valid) begin
            errors++;
            $display("%0t: byte_valid expected %0d actual %0d", $time, exp.byte_valid,
                     got.byte_valid);
         end
         if (got.status !== exp.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
         end
         if (got.run_end !== exp.run_end) begin
            errors++;
            $display("%0t: run_end expected %0d actual %0d", $time, exp.run_end, got.run_end);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [fmf_pkg::CSR_IDX_W-1:0] csr_index;
   logic [fmf_pkg::CSR_DATA_W-1:0] csr_wdata;

   fmf_req_if req_if ();
   fmf_rsp_if rsp_if ();

   fragmenter_mirror mirror = new();
   bit pace_on = 1'b1;
   bit stall_on = 1'b1;
   int items_sent = 0;
   int quiet_cycles = 0;

   message_fragmenter_first_last u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // no item moving on either channel for too long means the block hung
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("message_fragmenter_first_last regression: fail");
            $finish;
         end
      end
   end

   function automatic fmf_pkg::req_item_type noise_item(fmf_pkg::op_type op);
      fmf_pkg::req_item_type it;
      it.op = op;
      it.channel = 8'($urandom);
      it.msg_id = 16'($urandom);
      it.body_bytes = $urandom;
      it.data_byte = 8'($urandom);
      return it;
   endfunction

   task automatic send_item(fmf_pkg::req_item_type it);
      int gap;
      gap = pace_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.op <= it.op;
      req_if.channel <= it.channel;
      req_if.msg_id <= it.msg_id;
      req_if.body_bytes <= it.body_bytes;
      req_if.data_byte <= it.data_byte;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      mirror.note_request(it);
      items_sent++;
   endtask

   task automatic send_begin(logic [7:0] ch, logic [15:0] id, logic [31:0] len);
      fmf_pkg::req_item_type it;
      it = noise_item(fmf_pkg::OP_BEGIN);
      it.channel = ch;
      it.msg_id = id;
      it.body_bytes = len;
      send_item(it);
   endtask

   task automatic send_data(logic [7:0] b);
      fmf_pkg::req_item_type it;
      it = noise_item(fmf_pkg::OP_DATA);
      it.data_byte = b;
      send_item(it);
   endtask

   task automatic send_end();
      send_item(noise_item(fmf_pkg::OP_END));
   endtask

   task automatic send_abort();
      send_item(noise_item(fmf_pkg::OP_ABORT));
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (mirror.due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [fmf_pkg::CSR_IDX_W-1:0] idx,
                            logic [fmf_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      mirror.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic pick_config();
      logic [5:0] chunk;
      logic [7:0] fmask;
      logic [7:0] lmask;
      case ($urandom_range(0, 3))
         0: chunk = 6'($urandom_range(0, 63));
         1: chunk = 6'($urandom_range(0, 3));
         2: chunk = 6'($urandom_range(53, 63));
         default: chunk = 6'($urandom_range(4, 12));
      endcase
      case ($urandom_range(0, 2))
         0: fmask = 8'h00;
         1: fmask = 8'hFF;
         default: fmask = 8'($urandom);
      endcase
      case ($urandom_range(0, 2))
         0: lmask = 8'h00;
         1: lmask = 8'hFF;
         default: lmask = 8'($urandom);
      endcase
      write_csr(fmf_pkg::CSR_CHUNK_SIZE, {2'($urandom), chunk});
      write_csr(fmf_pkg::CSR_FIRST_MASK, fmask);
      write_csr(fmf_pkg::CSR_LAST_MASK, lmask);
      if ($urandom_range(0, 3) == 0) write_csr(CSR_UNUSED, 8'($urandom));
   endtask

   initial begin : rsp_side
      int stall;
      fmf_pkg::rsp_item_type got;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = stall_on ? $urandom_range(0, 14) : 0;
         repeat (stall) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got.frame_byte = rsp_if.frame_byte;
         got.byte_valid = rsp_if.byte_valid;
         got.status = fmf_pkg::status_type'(rsp_if.status);
         got.run_end = rsp_if.run_end;
         mirror.check_response(got);
      end
   end

   initial begin : req_side
      int kind;
      int len;
      int cnt;
      int busy_at;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.op = '0;
      req_if.channel = '0;
      req_if.msg_id = '0;
      req_if.body_bytes = '0;
      req_if.data_byte = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing open yet
      send_data(8'hA5);
      send_end();
      send_abort();
      // empty body: one frame carrying only the message id, first and last
      send_begin(8'hFF, 16'hFFFF, 32'd0);
      send_end();
      // total wraps to one byte, so the id alone already overruns it
      send_begin(8'h00, 16'h0000, 32'hFFFF_FFFF);
      send_data(8'h00);
      send_begin(8'h11, 16'h2222, 32'd5);
      send_end();
      send_begin(8'h5A, 16'h0F0F, 32'hFFFF_FFFD);
      send_data(8'hFF);
      send_abort();
      // byte past the announced length is dropped
      send_begin(8'h3C, 16'h8001, 32'd3);
      send_data(8'h00);
      send_data(8'hFF);
      send_data(8'hAA);
      send_data(8'h55);
      send_end();

      wait_results_done();
      write_csr(fmf_pkg::CSR_CHUNK_SIZE, 8'h00);
      write_csr(fmf_pkg::CSR_FIRST_MASK, 8'hFF);
      write_csr(fmf_pkg::CSR_LAST_MASK, 8'h00);
      write_csr(CSR_UNUSED, 8'h07);
      send_begin(8'h01, 16'h1234, 32'd4);
      repeat (4) send_data(8'($urandom));
      send_end();

      // chunk size lowered while a message is open
      wait_results_done();
      write_csr(fmf_pkg::CSR_CHUNK_SIZE, 8'hFF);
      write_csr(fmf_pkg::CSR_FIRST_MASK, 8'h01);
      write_csr(fmf_pkg::CSR_LAST_MASK, 8'h80);
      send_begin(8'h02, 16'hBEEF, 32'd10);
      repeat (4) send_data(8'($urandom));
      wait_results_done();
      write_csr(fmf_pkg::CSR_CHUNK_SIZE, 8'h04);
      send_data(8'h77);
      send_end();

      wait_results_done();
      pick_config();
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 5) == 0) begin
            wait_results_done();
            pick_config();
         end
         if ($urandom_range(0, 5) == 0) pace_on = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 5) == 0) stall_on = ($urandom_range(0, 2) != 0);
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(13, 60);
            busy_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : -1;
            send_begin(8'($urandom), 16'($urandom), 32'(len));
            for (int i = 0; i <= len; i++) begin
               if (i == busy_at) send_begin(8'($urandom), 16'($urandom), $urandom);
               if (i < len) send_data(8'($urandom));
            end
            send_end();
         end else if (kind == 7) begin
            len = $urandom_range(0, 10);
            if ($urandom_range(0, 1) == 0)
               cnt = len + $urandom_range(1, 3);
            else
               cnt = (len == 0) ? 0 : $urandom_range(0, len - 1);
            send_begin(8'($urandom), 16'($urandom), 32'(len));
            repeat (cnt) send_data(8'($urandom));
            send_end();
         end else if (kind == 8) begin
            send_begin(8'($urandom), 16'($urandom), $urandom);
            repeat ($urandom_range(0, 5)) send_data(8'($urandom));
            if ($urandom_range(0, 1) == 0)
               send_end();
            else
               send_abort();
         end else begin
            repeat ($urandom_range(1, 4))
               send_item(noise_item(fmf_pkg::op_type'($urandom_range(0, 3))));
            send_abort();
         end
      end

      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.due.size() != 0) begin
         mirror.errors++;
         $display("%0t: %0d expected results never arrived", $time, mirror.due.size());
      end
      if (mirror.errors == 0)
         $display("message_fragmenter_first_last regression: pass");
      else
         $display("message_fragmenter_first_last regression: fail");
      $finish;
   end

endmodule
